@@ rtl/core/mtrc_pkg.sv @@
package mtrc_pkg;

  localparam int ANGLE_FRAC_BITS = 10;
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int DEG             = 1 << ANGLE_FRAC_BITS;

  // field widths
  localparam int AZ_W    = 19;
  localparam int EL_W    = 19;
  localparam int TEL_W   = 18;
  localparam int AZR_W   = 20;
  localparam int ELR_W   = 19;
  localparam int GAIN_W  = 16;
  localparam int SLEW_W  = 18;
  localparam int LOW_W   = 17;
  localparam int SPD_W   = 18;
  localparam int CAUSE_W = 3;

  // internal widths
  localparam int DEL_W   = 20;
  localparam int WIDE_W  = 22;
  localparam int EMAG_W  = 19;
  localparam int RATE_W  = 19;
  localparam int MA_W    = GAIN_W + EMAG_W;
  localparam int PROD_W  = MA_W + EMAG_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int SPD_SHIFT = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int SH_W    = ACC_W - SPD_SHIFT;

  // stream widths
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_EL_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EL_SQUARE_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AZ_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AZ_SQUARE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ELEVATION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_WRAP    = 3'd6;

  localparam logic [GAIN_W-1:0] RST_EL_GAIN        = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_EL_SQUARE_GAIN = 16'd0;
  localparam logic [GAIN_W-1:0] RST_AZ_GAIN        = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_AZ_SQUARE_GAIN = 16'd0;
  localparam logic [SLEW_W-1:0] RST_MAX_SLEW       = 18'd20480;
  localparam logic [LOW_W-1:0]  RST_LOW_ELEVATION  = 17'd15360;
  localparam logic              RST_WRAP           = 1'b0;

  // stop causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_CW_LIMIT  = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_CCW_LIMIT = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_EL_HIGH   = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_EL_LOW    = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_OBJ_LOW   = 3'd5;

  // azimuth constants, unsigned
  localparam logic [AZ_W-1:0] AZ_FULL    = AZ_W'(360 * DEG);
  localparam logic [AZ_W-1:0] AZ_10      = AZ_W'(10 * DEG);
  localparam logic [AZ_W-1:0] AZ_90      = AZ_W'(90 * DEG);
  localparam logic [AZ_W-1:0] AZ_91      = AZ_W'(91 * DEG);
  localparam logic [AZ_W-1:0] AZ_92      = AZ_W'(92 * DEG);
  localparam logic [AZ_W-1:0] AZ_180     = AZ_W'(180 * DEG);
  localparam logic [AZ_W-1:0] AZ_269     = AZ_W'(269 * DEG);
  localparam logic [AZ_W-1:0] AZ_270     = AZ_W'(270 * DEG);
  localparam logic [AZ_W-1:0] AZ_350     = AZ_W'(350 * DEG);
  localparam logic [AZ_W-1:0] AZ_WRAP_HI = AZ_W'((359999 * DEG + 999) / 1000);
  localparam logic [AZ_W:0]   TWO_AZ_LO  = (AZ_W+1)'(3 * DEG);
  localparam logic [AZ_W:0]   TWO_AZ_HI  = (AZ_W+1)'(717 * DEG);

  // signed constants
  localparam logic signed [WIDE_W-1:0] S_HALF  = WIDE_W'(180 * DEG);
  localparam logic signed [WIDE_W-1:0] S_NHALF = -WIDE_W'(180 * DEG);
  localparam logic signed [WIDE_W-1:0] S_FULL  = WIDE_W'(360 * DEG);
  localparam logic signed [DEL_W-1:0]  EL_90   = DEL_W'(90 * DEG);
  localparam logic signed [DEL_W-1:0]  EL_15   = DEL_W'(15 * DEG);
  localparam logic signed [DEL_W-1:0]  EL_ONE  = DEL_W'(DEG);

  // multiplier operand select
  localparam logic [1:0] MSRC_GAIN = 2'd0;
  localparam logic [1:0] MSRC_SQG  = 2'd1;
  localparam logic [1:0] MSRC_PROD = 2'd2;

  // accumulator ops
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_BASE = 2'd1;
  localparam logic [1:0] ACC_LIN  = 2'd2;

  typedef struct packed {
    logic [AZ_W-1:0]  scope_azimuth;
    logic [EL_W-1:0]  scope_elevation;
    logic [AZ_W-1:0]  target_azimuth;
    logic [TEL_W-1:0] target_elevation;
    logic [AZR_W-1:0] target_az_rate;
    logic [ELR_W-1:0] target_el_rate;
    logic             tracking_on;
    logic             in_stow_window;
  } in_t;

  typedef struct packed {
    logic                az_drive_dir;
    logic                el_drive_dir;
    logic                wrap;
    logic [CAUSE_W-1:0]  stop_cause;
    logic                el_kill;
    logic                az_kill;
    logic [EMAG_W-1:0]   el_emag;
    logic                el_lin_sub;
    logic [EMAG_W-1:0]   az_emag;
    logic                az_lin_sub;
    logic [RATE_W-1:0]   el_rate;
    logic [RATE_W-1:0]   az_rate;
  } geom_t;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] mul_src;
    logic [1:0] acc_op;
  } alu_ctl_t;

  typedef struct packed {
    logic               az_drive_dir;
    logic               el_drive_dir;
    logic [SPD_W-1:0]   az_speed_cmd;
    logic [SPD_W-1:0]   el_speed_cmd;
    logic               stop_request;
    logic [CAUSE_W-1:0] stop_cause;
    logic               wrap_dir;
  } res_t;

endpackage

@@ rtl/core/mtrc_front.sv @@
module mtrc_front import mtrc_pkg::*; (
  input  logic             clk_i,
  input  logic             red_en_i,
  input  logic             geo_en_i,
  input  in_t              in_i,
  input  logic             wrap_i,
  input  logic [LOW_W-1:0] low_elev_i,
  output geom_t            geom_o
);

  typedef struct packed {
    logic [AZ_W-1:0]   az;
    logic [AZ_W-1:0]   taz;
    logic [EL_W-1:0]   el;
    logic [TEL_W-1:0]  tel;
    logic [DEL_W-1:0]  del;
    logic [RATE_W-1:0] az_rate;
    logic [RATE_W-1:0] el_rate;
    logic              tracking;
    logic              window;
  } red_t;

  red_t  red_d, red_q;
  geom_t geom_d, geom_q;

  logic signed [WIDE_W-1:0] azr_x, azr_w, azr_abs;
  logic signed [DEL_W-1:0]  elr_x, elr_abs;

  // first step: range reduction, elevation error, rate wrap
  always_comb begin
    red_d = '0;
    red_d.az = (in_i.scope_azimuth >= AZ_FULL) ? in_i.scope_azimuth - AZ_FULL
                                               : in_i.scope_azimuth;
    red_d.taz = (in_i.target_azimuth >= AZ_FULL) ? in_i.target_azimuth - AZ_FULL
                                                 : in_i.target_azimuth;
    red_d.el  = in_i.scope_elevation;
    red_d.tel = in_i.target_elevation;
    red_d.del = {in_i.scope_elevation[EL_W-1], in_i.scope_elevation}
              - {{(DEL_W-TEL_W){in_i.target_elevation[TEL_W-1]}}, in_i.target_elevation};

    azr_x = $signed({{(WIDE_W-AZR_W){in_i.target_az_rate[AZR_W-1]}}, in_i.target_az_rate});
    if (azr_x > S_HALF) begin
      azr_w = azr_x - S_FULL;
    end else if (azr_x < S_NHALF) begin
      azr_w = azr_x + S_FULL;
    end else begin
      azr_w = azr_x;
    end
    azr_abs = azr_w[WIDE_W-1] ? -azr_w : azr_w;
    red_d.az_rate = azr_abs[RATE_W-1:0];

    elr_x   = $signed({in_i.target_el_rate[ELR_W-1], in_i.target_el_rate});
    elr_abs = elr_x[DEL_W-1] ? -elr_x : elr_x;
    red_d.el_rate = elr_abs[RATE_W-1:0];

    red_d.tracking = in_i.tracking_on;
    red_d.window   = in_i.in_stow_window;
  end

  always_ff @(posedge clk_i) begin
    if (red_en_i) begin
      red_q <= red_d;
    end
  end

  logic signed [WIDE_W-1:0] daz0, daz, daz_abs;
  logic signed [DEL_W-1:0]  del_s, del_abs, el_x, tel_x, low_x, low_p1;
  logic [AZ_W:0]            two_az;
  logic                     wrap_new, scope_north, tgt_north, tgt_east, in_slot;
  logic                     az_dir, el_dir;

  // second step: azimuth error, wrap update, directions, limits
  always_comb begin
    geom_d = '0;
    daz0 = $signed({{(WIDE_W-AZ_W){1'b0}}, red_q.taz})
         - $signed({{(WIDE_W-AZ_W){1'b0}}, red_q.az});
    if (daz0 > S_HALF) begin
      daz = daz0 - S_FULL;
    end else if (daz0 < S_NHALF) begin
      daz = daz0 + S_FULL;
    end else begin
      daz = daz0;
    end
    daz_abs = daz[WIDE_W-1] ? -daz : daz;

    del_s   = $signed(red_q.del);
    del_abs = del_s[DEL_W-1] ? -del_s : del_s;

    if (red_q.az < AZ_10 && wrap_i) begin
      wrap_new = 1'b0;
    end else if (red_q.az > AZ_350 && red_q.az < AZ_WRAP_HI && !wrap_i) begin
      wrap_new = 1'b1;
    end else begin
      wrap_new = wrap_i;
    end

    scope_north = red_q.az > AZ_270 || red_q.az < AZ_90;
    tgt_north   = red_q.taz > AZ_270 || red_q.taz < AZ_90;
    tgt_east    = red_q.taz != '0 && red_q.taz < AZ_180;

    if (!scope_north && tgt_north) begin
      az_dir = !wrap_new;
    end else begin
      az_dir = !(!daz[WIDE_W-1] && daz != '0);
    end
    el_dir = !del_s[DEL_W-1];

    two_az  = {red_q.az, 1'b0};
    in_slot = two_az < TWO_AZ_LO || two_az > TWO_AZ_HI;

    el_x   = $signed({red_q.el[EL_W-1], red_q.el});
    tel_x  = $signed({{(DEL_W-TEL_W){red_q.tel[TEL_W-1]}}, red_q.tel});
    low_x  = $signed({{(DEL_W-LOW_W){1'b0}}, low_elev_i});
    low_p1 = low_x + EL_ONE;

    geom_d.az_drive_dir = az_dir;
    geom_d.el_drive_dir = el_dir;
    geom_d.wrap         = wrap_new;
    geom_d.el_kill      = (el_x < low_p1) && el_dir && !in_slot;
    geom_d.az_kill      = el_x < low_x;
    geom_d.el_emag      = del_abs[EMAG_W-1:0];
    geom_d.el_lin_sub   = tgt_east ^ del_s[DEL_W-1];
    geom_d.az_emag      = daz_abs[EMAG_W-1:0];
    geom_d.az_lin_sub   = tgt_north ^ daz[WIDE_W-1];
    geom_d.el_rate      = red_q.el_rate;
    geom_d.az_rate      = red_q.az_rate;

    geom_d.stop_cause = CAUSE_NONE;
    if (red_q.tracking) begin
      priority if (red_q.az >= AZ_269 && red_q.az < AZ_270 && !wrap_new) begin
        geom_d.stop_cause = CAUSE_CW_LIMIT;
      end else if (red_q.az >= AZ_91 && red_q.az < AZ_92 && wrap_new) begin
        geom_d.stop_cause = CAUSE_CCW_LIMIT;
      end else if (el_x > EL_90 && !el_dir) begin
        geom_d.stop_cause = CAUSE_EL_HIGH;
      end else if (el_x < EL_15 && el_dir && !red_q.window) begin
        geom_d.stop_cause = CAUSE_EL_LOW;
      end else if (tel_x < EL_15 && two_az > TWO_AZ_LO) begin
        geom_d.stop_cause = CAUSE_OBJ_LOW;
      end else begin
        geom_d.stop_cause = CAUSE_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (geo_en_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

@@ rtl/core/mtrc_alu.sv @@
module mtrc_alu import mtrc_pkg::*; (
  input  logic              clk_i,
  input  alu_ctl_t          ctl_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic [GAIN_W-1:0] sq_gain_i,
  input  logic [EMAG_W-1:0] emag_i,
  input  logic [RATE_W-1:0] rate_i,
  input  logic              lin_sub_i,
  input  logic [SLEW_W-1:0] max_slew_i,
  output logic [SPD_W-1:0]  speed_o
);

  logic [MA_W-1:0]   mul_a;
  logic [PROD_W-1:0] mul_p, prod_q;
  logic [ACC_W-1:0]  acc_d, acc_q, base_x, lin_x, mag;
  logic [SH_W-1:0]   sh;

  always_comb begin
    unique case (ctl_i.mul_src)
      MSRC_GAIN: mul_a = {{(MA_W-GAIN_W){1'b0}}, gain_i};
      MSRC_SQG:  mul_a = {{(MA_W-GAIN_W){1'b0}}, sq_gain_i};
      MSRC_PROD: mul_a = prod_q[MA_W-1:0];
      default:   mul_a = '0;
    endcase
  end

  assign mul_p = {{(PROD_W-MA_W){1'b0}}, mul_a} * {{(PROD_W-EMAG_W){1'b0}}, emag_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  assign base_x = {{(ACC_W-RATE_W){1'b0}}, rate_i} << SPD_SHIFT;
  assign lin_x  = {{(ACC_W-PROD_W){1'b0}}, prod_q} << ANGLE_FRAC_BITS;

  always_comb begin
    unique case (ctl_i.acc_op)
      ACC_BASE: acc_d = base_x + {{(ACC_W-PROD_W){1'b0}}, prod_q};
      ACC_LIN:  acc_d = lin_sub_i ? acc_q - lin_x : acc_q + lin_x;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_op != ACC_HOLD) begin
      acc_q <= acc_d;
    end
  end

  assign mag = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign sh  = mag[ACC_W-1:SPD_SHIFT];
  assign speed_o = (sh > {{(SH_W-SLEW_W){1'b0}}, max_slew_i}) ? max_slew_i
                                                                : sh[SPD_W-1:0];

endmodule

@@ rtl/core/mount_tracking_rate_command.sv @@
// Alt-azimuth tracking rate command.
// Input stream (s_axis): one item per servo tick with scope and target
// azimuth/elevation and target rates. Output stream (m_axis): one result
// item per input item, with drive directions, saturated axis speeds, the
// limit stop flag and cause, and the cable-wrap direction after the update.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write gains, slew ceiling,
// low elevation, and load the wrap direction; write only while idle.
// Timing: an item is accepted only in idle, and no new item is taken until
// the previous one has been loaded into the output register. The single
// shared multiplier and accumulator run five steps per axis for the two
// axes one after the other, after two steps of angle reduction and limit
// logic; one step then loads the output register, and the sequencer returns
// to idle, where the next item is accepted.
// A finished result sits in the output register; while it waits, the next
// item is accepted and processed. If the receiver stalls, the next result
// holds in the last step until the output register frees.
// Reset loads default gains and clears the wrap direction to clockwise.
module mount_tracking_rate_command import mtrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // scope_azimuth, scope_elevation, target_azimuth, target_elevation,
  // target_az_rate, target_el_rate, tracking_on, in_stow_window, pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // az_drive_dir, el_drive_dir, az_speed_cmd, el_speed_cmd, stop_request,
  // stop_cause, wrap_dir, pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_GEO  = 4'd2;
  localparam logic [3:0] S_SQA  = 4'd3;
  localparam logic [3:0] S_SQB  = 4'd4;
  localparam logic [3:0] S_ACC1 = 4'd5;
  localparam logic [3:0] S_ACC2 = 4'd6;
  localparam logic [3:0] S_SAT  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state_q, state_d;
  logic              axis_q, axis_d;  // 0 elevation, 1 azimuth
  logic [GAIN_W-1:0] el_gain_q, el_sq_gain_q, az_gain_q, az_sq_gain_q;
  logic [SLEW_W-1:0] max_slew_q;
  logic [LOW_W-1:0]  low_elev_q;
  logic              wrap_q;
  logic              out_valid_q;
  res_t              res_q;
  in_t               in_q;
  geom_t             geom;
  alu_ctl_t          alu_ctl;
  logic [SPD_W-1:0]  speed, el_spd_q, az_spd_q;
  logic              in_acc, out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.scope_azimuth    <= s_axis_tdata_i[18:0];
      in_q.scope_elevation  <= s_axis_tdata_i[37:19];
      in_q.target_azimuth   <= s_axis_tdata_i[56:38];
      in_q.target_elevation <= s_axis_tdata_i[74:57];
      in_q.target_az_rate   <= s_axis_tdata_i[94:75];
      in_q.target_el_rate   <= s_axis_tdata_i[113:95];
      in_q.tracking_on      <= s_axis_tdata_i[114];
      in_q.in_stow_window   <= s_axis_tdata_i[115];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_gain_q    <= RST_EL_GAIN;
      el_sq_gain_q <= RST_EL_SQUARE_GAIN;
      az_gain_q    <= RST_AZ_GAIN;
      az_sq_gain_q <= RST_AZ_SQUARE_GAIN;
      max_slew_q   <= RST_MAX_SLEW;
      low_elev_q   <= RST_LOW_ELEVATION;
      wrap_q       <= RST_WRAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EL_GAIN:        el_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_EL_SQUARE_GAIN: el_sq_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_AZ_GAIN:        az_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_AZ_SQUARE_GAIN: az_sq_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_MAX_SLEW:       max_slew_q   <= cfg_data_i[SLEW_W-1:0];
        REG_LOW_ELEVATION:  low_elev_q   <= cfg_data_i[LOW_W-1:0];
        REG_START_WRAP:     wrap_q       <= cfg_data_i[0];
        default: ;
      endcase
    end else if (state_q == S_DONE) begin
      wrap_q <= geom.wrap;
    end
  end

  mtrc_front u_front (
    .clk_i      (clk_i),
    .red_en_i   (state_q == S_RED),
    .geo_en_i   (state_q == S_GEO),
    .in_i       (in_q),
    .wrap_i     (wrap_q),
    .low_elev_i (low_elev_q),
    .geom_o     (geom)
  );

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    alu_ctl = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RED;
        end
      end
      S_RED: state_d = S_GEO;
      S_GEO: begin
        axis_d  = 1'b0;
        state_d = S_SQA;
      end
      S_SQA: begin
        alu_ctl.mul_en  = 1'b1;
        alu_ctl.mul_src = MSRC_SQG;
        state_d = S_SQB;
      end
      S_SQB: begin
        alu_ctl.mul_en  = 1'b1;
        alu_ctl.mul_src = MSRC_PROD;
        state_d = S_ACC1;
      end
      S_ACC1: begin
        alu_ctl.mul_en  = 1'b1;
        alu_ctl.mul_src = MSRC_GAIN;
        alu_ctl.acc_op  = ACC_BASE;
        state_d = S_ACC2;
      end
      S_ACC2: begin
        alu_ctl.acc_op = ACC_LIN;
        state_d = S_SAT;
      end
      S_SAT: begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_SQA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  mtrc_alu u_alu (
    .clk_i      (clk_i),
    .ctl_i      (alu_ctl),
    .gain_i     (axis_q ? az_gain_q : el_gain_q),
    .sq_gain_i  (axis_q ? az_sq_gain_q : el_sq_gain_q),
    .emag_i     (axis_q ? geom.az_emag : geom.el_emag),
    .rate_i     (axis_q ? geom.az_rate : geom.el_rate),
    .lin_sub_i  (axis_q ? geom.az_lin_sub : geom.el_lin_sub),
    .max_slew_i (max_slew_q),
    .speed_o    (speed)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_SAT) begin
      if (axis_q) begin
        az_spd_q <= geom.az_kill ? '0 : speed;
      end else begin
        el_spd_q <= geom.el_kill ? '0 : speed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q.az_drive_dir <= geom.az_drive_dir;
      res_q.el_drive_dir <= geom.el_drive_dir;
      res_q.az_speed_cmd <= az_spd_q;
      res_q.el_speed_cmd <= el_spd_q;
      res_q.stop_request <= (geom.stop_cause != CAUSE_NONE);
      res_q.stop_cause   <= geom.stop_cause;
      res_q.wrap_dir     <= geom.wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, res_q.wrap_dir, res_q.stop_cause, res_q.stop_request,
                            res_q.el_speed_cmd, res_q.az_speed_cmd,
                            res_q.el_drive_dir, res_q.az_drive_dir};

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RED))
    else $error("item accepted but sequencer did not start");

  a_stop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_q.stop_request == (res_q.stop_cause != CAUSE_NONE)))
    else $error("stop flag and cause disagree");

  a_speed_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_q.az_speed_cmd <= max_slew_q &&
                         res_q.el_speed_cmd <= max_slew_q))
    else $error("speed above slew ceiling");

  a_stop_tracking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && geom.stop_cause != CAUSE_NONE) |-> in_q.tracking_on)
    else $error("stop flagged while not tracking");
`endif

endmodule

@@ sim/mount_tracking_rate_command_tb.sv @@
`timescale 1ns / 1ps

import mtrc_pkg::*;

class rate_cmd_model;
  logic [GAIN_W-1:0] el_gain;
  logic [GAIN_W-1:0] el_sq_gain;
  logic [GAIN_W-1:0] az_gain;
  logic [GAIN_W-1:0] az_sq_gain;
  logic [SLEW_W-1:0] max_slew;
  logic [LOW_W-1:0]  low_el;
  logic              wrap;
  res_t              pending_cmds[$];
  int unsigned       mismatches;

  function new();
    el_gain    = RST_EL_GAIN;
    el_sq_gain = RST_EL_SQUARE_GAIN;
    az_gain    = RST_AZ_GAIN;
    az_sq_gain = RST_AZ_SQUARE_GAIN;
    max_slew   = RST_MAX_SLEW;
    low_el     = RST_LOW_ELEVATION;
    wrap       = RST_WRAP;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_EL_GAIN:        el_gain    = v[GAIN_W-1:0];
      REG_EL_SQUARE_GAIN: el_sq_gain = v[GAIN_W-1:0];
      REG_AZ_GAIN:        az_gain    = v[GAIN_W-1:0];
      REG_AZ_SQUARE_GAIN: az_sq_gain = v[GAIN_W-1:0];
      REG_MAX_SLEW:       max_slew   = v[SLEW_W-1:0];
      REG_LOW_ELEVATION:  low_el     = v[LOW_W-1:0];
      REG_START_WRAP:     wrap       = v[0];
      default: ;
    endcase
  endfunction

  // |rate*g -/+ gain*err + sq_gain*err^2| at scale DEG*2^GAIN_FRAC_BITS, truncated, capped at max_slew
  function longint axis_speed(longint rate_mag, longint err, longint gain, longint sq_gain,
                              bit sub);
    longint emag, base, lin, sq, s, v;
    emag = (err < 0) ? -err : err;
    base = rate_mag * (longint'(1) << GAIN_FRAC_BITS) * DEG;
    lin  = gain * err * DEG;
    sq   = emag * emag * sq_gain;
    s    = sub ? (base - lin + sq) : (base + lin + sq);
    if (s < 0) s = -s;
    v = s >>> SPD_SHIFT;
    if (v > longint'(max_slew)) v = longint'(max_slew);
    return v;
  endfunction

  function void take_tick(in_t t);
    longint az, el, taz, tel, azr, elr, low, daz, del, az_spd, el_spd;
    bit scope_north, tgt_north, tgt_east, in_slot;
    logic az_dir, el_dir;
    logic [CAUSE_W-1:0] cause;
    res_t r;
    az  = longint'(t.scope_azimuth) % (360 * DEG);
    el  = longint'($signed(t.scope_elevation));
    taz = longint'(t.target_azimuth) % (360 * DEG);
    tel = longint'($signed(t.target_elevation));
    azr = longint'($signed(t.target_az_rate));
    elr = longint'($signed(t.target_el_rate));
    low = longint'(low_el);

    if (az < 10 * DEG && wrap == 1'b1)
      wrap = 1'b0;
    else if (az > 350 * DEG && az * 1000 < 359999 * DEG && wrap == 1'b0)
      wrap = 1'b1;

    scope_north = az > 270 * DEG || az < 90 * DEG;
    tgt_north   = taz > 270 * DEG || taz < 90 * DEG;
    tgt_east    = taz > 0 && taz < 180 * DEG;

    if (azr > 180 * DEG)
      azr -= 360 * DEG;
    else if (azr < -180 * DEG)
      azr += 360 * DEG;

    del = el - tel;
    daz = taz - az;
    if (daz > 180 * DEG)
      daz -= 360 * DEG;
    else if (daz < -180 * DEG)
      daz += 360 * DEG;

    az_dir = (daz > 0) ? 1'b0 : 1'b1;
    if (!scope_north && tgt_north) az_dir = (wrap == 1'b0) ? 1'b1 : 1'b0;
    el_dir = (del >= 0) ? 1'b1 : 1'b0;

    in_slot = 2 * az < 3 * DEG || 2 * az > 717 * DEG;

    el_spd = axis_speed((elr < 0) ? -elr : elr, del, longint'(el_gain),
                        longint'(el_sq_gain), tgt_east);
    if (el < low + DEG && el_dir != 1'b0 && !in_slot) el_spd = 0;
    az_spd = axis_speed((azr < 0) ? -azr : azr, daz, longint'(az_gain),
                        longint'(az_sq_gain), tgt_north);
    if (el < low) az_spd = 0;

    cause = CAUSE_NONE;
    if (t.tracking_on) begin
      if (az >= 269 * DEG && az < 270 * DEG && wrap == 1'b0)
        cause = CAUSE_CW_LIMIT;
      else if (az >= 91 * DEG && az < 92 * DEG && wrap == 1'b1)
        cause = CAUSE_CCW_LIMIT;
      else if (el > 90 * DEG && el_dir == 1'b0)
        cause = CAUSE_EL_HIGH;
      else if (el < 15 * DEG && el_dir == 1'b1 && !t.in_stow_window)
        cause = CAUSE_EL_LOW;
      else if (tel < 15 * DEG && 2 * az > 3 * DEG)
        cause = CAUSE_OBJ_LOW;
    end

    r.az_drive_dir = az_dir;
    r.el_drive_dir = el_dir;
    r.az_speed_cmd = az_spd[SPD_W-1:0];
    r.el_speed_cmd = el_spd[SPD_W-1:0];
    r.stop_request = (cause != CAUSE_NONE);
    r.stop_cause   = cause;
    r.wrap_dir     = wrap;
    pending_cmds.push_back(r);
  endfunction

  function void cmp(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, e, g);
    end
  endfunction

  function void check_cmd(logic [OUT_TDATA_W-1:0] d);
    res_t e;
    if (pending_cmds.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, actual %h", $time, d);
      return;
    end
    e = pending_cmds.pop_front();
    cmp("az_drive_dir", 32'(e.az_drive_dir), 32'(d[0]));
    cmp("el_drive_dir", 32'(e.el_drive_dir), 32'(d[1]));
    cmp("az_speed_cmd", 32'(e.az_speed_cmd), 32'(d[19:2]));
    cmp("el_speed_cmd", 32'(e.el_speed_cmd), 32'(d[37:20]));
    cmp("stop_request", 32'(e.stop_request), 32'(d[38]));
    cmp("stop_cause", 32'(e.stop_cause), 32'(d[41:39]));
    cmp("wrap_dir", 32'(e.wrap_dir), 32'(d[42]));
  endfunction
endclass

module mount_tracking_rate_command_tb;

  localparam int AZ_TOP = 368639;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rate_cmd_model cmd_model;
  int stall_mode = 0;
  int stall_left = 0;

  mount_tracking_rate_command DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #(20_000_000);
    $display("mount_tracking_rate_command verification failed");
    $finish;
  end

  // receiver: stall pattern switches between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) cmd_model.check_cmd(m_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic in_t tick(int az, int el, int taz, int tel, int azr, int elr,
                               bit trk, bit win);
    in_t t;
    t.scope_azimuth    = AZ_W'(az);
    t.scope_elevation  = EL_W'(el);
    t.target_azimuth   = AZ_W'(taz);
    t.target_elevation = TEL_W'(tel);
    t.target_az_rate   = AZR_W'(azr);
    t.target_el_rate   = ELR_W'(elr);
    t.tracking_on      = trk;
    t.in_stow_window   = win;
    return t;
  endfunction

  function automatic in_t rand_tick();
    in_t t;
    int az, el, taz, tel, azr, elr;
    t = tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) return t;
    case ($urandom_range(0, 7))
      0: az = span(0, 12 * DEG);
      1: az = span(348 * DEG, AZ_TOP);
      2: az = span(268 * DEG, 271 * DEG);
      3: az = span(89 * DEG, 93 * DEG);
      default: az = span(0, AZ_TOP);
    endcase
    case ($urandom_range(0, 5))
      0: el = span(-184320, 184319);
      1: el = int'(cmd_model.low_el) + span(-2 * DEG, 2 * DEG);
      2: el = span(13 * DEG, 17 * DEG);
      3: el = span(88 * DEG, 93 * DEG);
      default: el = span(0, 90 * DEG);
    endcase
    taz = ($urandom_range(0, 2) == 0) ? span(0, AZ_TOP)
                                      : (az + span(-3 * DEG, 3 * DEG) + 360 * DEG) % (360 * DEG);
    tel = ($urandom_range(0, 2) == 0) ? span(-92160, 92160) : el + span(-3 * DEG, 3 * DEG);
    azr = ($urandom_range(0, 3) == 0) ? span(-368640, 368640) : span(-3 * DEG, 3 * DEG);
    elr = ($urandom_range(0, 3) == 0) ? span(-184320, 184320) : span(-3 * DEG, 3 * DEG);
    return tick(az, el, taz, tel, azr, elr, $urandom_range(0, 3) != 0,
                1'($urandom_range(0, 1)));
  endfunction

  task automatic send_item(input in_t t);
    s_tdata  <= {4'b0, t.in_stow_window, t.tracking_on, t.target_el_rate, t.target_az_rate,
                 t.target_elevation, t.target_azimuth, t.scope_elevation, t.scope_azimuth};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    cmd_model.take_tick(t);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (cmd_model.pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] eg, esg, ag, asg, slew, low,
                              input logic wrap);
    logic [CFG_DATA_W-1:0] vals [7];
    vals[REG_EL_GAIN]        = eg;
    vals[REG_EL_SQUARE_GAIN] = esg;
    vals[REG_AZ_GAIN]        = ag;
    vals[REG_AZ_SQUARE_GAIN] = asg;
    vals[REG_MAX_SLEW]       = slew;
    vals[REG_LOW_ELEVATION]  = low;
    vals[REG_START_WRAP]     = {{(CFG_DATA_W-1){1'b0}}, wrap};
    for (int i = 0; i < 7; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      cmd_model.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int burst_left;
    int gap;
    cmd_model = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    send_item(tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(tick(0, 45 * DEG, 180 * DEG, 45 * DEG, DEG, DEG, 1, 0));
    send_item(tick(355 * DEG, 45 * DEG, 10 * DEG, 40 * DEG, 0, 0, 1, 0));
    send_item(tick(91 * DEG + 512, 45 * DEG, 100 * DEG, 45 * DEG, DEG, 0, 1, 0));
    send_item(tick(5 * DEG, 45 * DEG, 6 * DEG, 10 * DEG, 0, DEG, 1, 0));
    send_item(tick(269 * DEG + 512, 45 * DEG, 268 * DEG, 45 * DEG, 0, 0, 1, 0));
    send_item(tick(180 * DEG, 95 * DEG, 180 * DEG, 100 * DEG, 0, 0, 1, 0));
    send_item(tick(180 * DEG, 10 * DEG, 181 * DEG, 5 * DEG, DEG, DEG, 1, 0));
    send_item(tick(180 * DEG, 10 * DEG, 181 * DEG, 5 * DEG, DEG, DEG, 1, 1));
    send_item(tick(DEG, 10 * DEG, 2 * DEG, 5 * DEG, DEG, DEG, 1, 1));
    send_item(tick(180 * DEG, 30 * DEG, 0, 30 * DEG, 0, 0, 1, 0));
    send_item(tick(180 * DEG, 30 * DEG, 45 * DEG, 20 * DEG, DEG, DEG, 1, 0));
    send_item(tick(524287, -262144, 524287, -131072, -524288, -262144, 1, 0));
    send_item(tick(524287, 262143, 0, 131071, 524287, 262143, 1, 1));
    send_item(tick(100 * DEG, 50 * DEG, 90 * DEG, 50 * DEG, 368640, -184320, 0, 0));
    send_item(tick(100 * DEG, 50 * DEG, 110 * DEG, 50 * DEG, -368640, 184320, 0, 0));
    send_item(tick(AZ_TOP, 40 * DEG, 1, 92160, -200000, 0, 1, 0));
    send_item(tick(350 * DEG, 40 * DEG, 350 * DEG, -92160, 0, 0, 1, 0));
    send_item(tick(270 * DEG, 16 * DEG, 90 * DEG, 16 * DEG, 0, 0, 1, 0));
    send_item(tick(90 * DEG, 16 * DEG, 270 * DEG, 15 * DEG, 0, 0, 1, 0));
    send_item(tick(200 * DEG, 16 * DEG - 1, 200 * DEG, 15 * DEG, 0, 0, 1, 0));
    send_item(tick(200 * DEG, 15 * DEG, 200 * DEG, 16 * DEG, 0, 0, 1, 0));
    send_item(tick(1535, 14 * DEG, 1535, 13 * DEG, 0, 0, 1, 1));
    send_item(tick(30 * DEG, 90 * DEG + 1, 60 * DEG, 90 * DEG + 2, 0, 0, 1, 0));
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: program_regs(0, 0, 0, 0, 0, 0, 1'b1);
        1: program_regs(65535, 65535, 65535, 65535, 262143, 92160, 1'b0);
        2: program_regs(4096, 40, 4096, 40, 262143, 131071, 1'b1);
        default: program_regs(CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 8192)),
                              CFG_DATA_W'($urandom_range(0, 256)),
                              CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 8192)),
                              CFG_DATA_W'($urandom_range(0, 256)),
                              CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 262143)
                                                               : $urandom_range(1000, 40000)),
                              CFG_DATA_W'($urandom_range(0, 92160)),
                              1'($urandom_range(0, 1)));
      endcase
      burst_left = 0;
      for (int i = 0; i < 155; i++) begin
        if ($urandom_range(0, 63) == 0) begin
          drain();
        end else if (burst_left == 0) begin
          gap = $urandom_range(0, 12);
          if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        send_item(rand_tick());
        if (burst_left != 0) burst_left--;
      end
      drain();
    end

    if (cmd_model.mismatches == 0 && cmd_model.pending_cmds.size() == 0)
      $display("mount_tracking_rate_command verification clean");
    else
      $display("mount_tracking_rate_command verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mtrc_pkg.sv
rtl/core/mtrc_front.sv
rtl/core/mtrc_alu.sv
rtl/core/mount_tracking_rate_command.sv
sim/mount_tracking_rate_command_tb.sv
